// File: hw/rtl/ecpr_pkg.sv
package ecpr_pkg;

    // Widths fixed by the port payload
    localparam int unsigned REQ_PAGE_W = 16;
    localparam int unsigned RES_IDX_W  = 2;
    localparam int unsigned CNT_W      = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic [REQ_PAGE_W-1:0] page_id;
        logic                  is_write;
    } t_req;

    typedef struct packed {
        logic                 hit;
        logic [RES_IDX_W-1:0] frame_index;
        logic [CNT_W-1:0]     fault_total;
        logic [CNT_W-1:0]     access_total;
    } t_res;

endpackage

// File: hw/rtl/ecpr_front.sv
module ecpr_front #(
    parameter int unsigned PAGE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    input  ecpr_pkg::t_req       i_req,
    output logic                 o_req_stall,
    output logic                 o_item_valid,
    output logic [PAGE_BITS-1:0] o_item_page,
    output logic                 o_item_wr,
    input  logic                 i_item_pop
);

    localparam int unsigned DEPTH = 2;
    localparam int unsigned EXT_W = 32;

    logic [PAGE_BITS-1:0] r_page [DEPTH];
    logic [DEPTH-1:0]     r_wr;
    logic                 r_wptr, n_wptr;
    logic                 r_rptr, n_rptr;
    logic [1:0]           r_count, n_count;
    logic [EXT_W-1:0]     page_ext;
    logic                 push;

    // Take the page number to the stored page width
    assign page_ext = {{(EXT_W - ecpr_pkg::REQ_PAGE_W){1'b0}}, i_req.page_id};

    assign o_req_stall  = (r_count == 2'(DEPTH));
    assign push         = i_req_valid && !o_req_stall;
    assign o_item_valid = (r_count != 2'd0);
    assign o_item_page  = r_page[r_rptr];
    assign o_item_wr    = r_wr[r_rptr];

    // Advance pointers and fill count
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push) begin
            n_wptr = !r_wptr;
        end
        if (i_item_pop) begin
            n_rptr = !r_rptr;
        end
        if (push && !i_item_pop) begin
            n_count = r_count + 2'd1;
        end else if (!push && i_item_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Hold queued requests
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_page[r_wptr] <= page_ext[PAGE_BITS-1:0];
            r_wr[r_wptr]   <= i_req.is_write;
        end
    end

endmodule

// File: hw/rtl/ecpr_back.sv
module ecpr_back #(
    parameter int unsigned FRAMES    = 3,
    parameter int unsigned PAGE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_item_valid,
    input  logic [PAGE_BITS-1:0] i_item_page,
    input  logic                 i_item_wr,
    output logic                 o_item_pop,
    output logic                 o_res_valid,
    output ecpr_pkg::t_res       o_res,
    input  logic                 i_res_stall
);

    localparam int unsigned FW        = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int unsigned SWEEP_LEN = 2 * FRAMES;
    localparam int unsigned SW        = $clog2(SWEEP_LEN + 1);
    localparam int unsigned CW        = ecpr_pkg::CNT_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LOOK  = 2'd1;
    localparam logic [1:0] S_SWEEP = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]           r_state, n_state;
    logic [PAGE_BITS-1:0] r_page [FRAMES];
    logic [FRAMES-1:0]    r_valid, n_valid;
    logic [FRAMES-1:0]    r_use, n_use;
    logic [FRAMES-1:0]    r_dirty, n_dirty;
    logic [FW-1:0]        r_hand, n_hand;
    logic [SW-1:0]        r_steps, n_steps;
    logic [PAGE_BITS-1:0] r_cur_page;
    logic                 r_cur_wr;
    logic [FW-1:0]        r_slot, n_slot;
    logic                 r_hit, n_hit;
    logic [CW-1:0]        r_faults, n_faults;
    logic [CW-1:0]        r_accesses, n_accesses;
    logic                 r_res_valid, n_res_valid;
    ecpr_pkg::t_res       r_res, n_res;

    logic                 look_hit;
    logic [FW-1:0]        look_idx;
    logic                 hand_clear;
    logic [FW-1:0]        hand_next;
    logic                 replace;
    logic                 res_free;
    logic [FW+1:0]        slot_ext;

    // Compare all resident pages, lowest match wins
    always_comb begin
        look_hit = 1'b0;
        look_idx = '0;
        for (int f = FRAMES - 1; f >= 0; f--) begin
            if (r_valid[f] && (r_page[f] == r_cur_page)) begin
                look_hit = 1'b1;
                look_idx = FW'(f);
            end
        end
    end

    assign hand_clear = !r_valid[r_hand] || (!r_use[r_hand] && !r_dirty[r_hand]);
    assign hand_next  = (r_hand == FW'(FRAMES - 1)) ? '0 : r_hand + FW'(1);
    assign replace    = hand_clear || (r_steps == SW'(SWEEP_LEN));
    assign res_free   = !r_res_valid || !i_res_stall;
    assign slot_ext   = {2'b00, r_slot};
    assign o_item_pop = (r_state == S_IDLE) && i_item_valid;

    // Sequence lookup, sweep and result
    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_use       = r_use;
        n_dirty     = r_dirty;
        n_hand      = r_hand;
        n_steps     = r_steps;
        n_slot      = r_slot;
        n_hit       = r_hit;
        n_faults    = r_faults;
        n_accesses  = r_accesses;
        n_res_valid = r_res_valid && i_res_stall;
        n_res       = r_res;
        case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (look_hit) begin
                    n_use[look_idx] = 1'b1;
                    if (r_cur_wr) begin
                        n_dirty[look_idx] = 1'b1;
                    end
                    n_slot  = look_idx;
                    n_hit   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_steps = '0;
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (replace) begin
                    n_valid[r_hand] = 1'b1;
                    n_use[r_hand]   = 1'b1;
                    n_dirty[r_hand] = r_cur_wr;
                    n_slot          = r_hand;
                    n_hit           = 1'b0;
                    n_state         = S_DONE;
                end else begin
                    n_use[r_hand] = 1'b0;
                    n_steps       = r_steps + SW'(1);
                end
                n_hand = hand_next;
            end
            S_DONE: begin
                if (res_free) begin
                    if (!r_hit && (r_faults != ecpr_pkg::CNT_MAX)) begin
                        n_faults = r_faults + CW'(1);
                    end
                    if (r_accesses != ecpr_pkg::CNT_MAX) begin
                        n_accesses = r_accesses + CW'(1);
                    end
                    n_res.hit          = r_hit;
                    n_res.frame_index  = slot_ext[1:0];
                    n_res.fault_total  = n_faults;
                    n_res.access_total = n_accesses;
                    n_res_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_use       <= '0;
            r_dirty     <= '0;
            r_hand      <= '0;
            r_steps     <= '0;
            r_hit       <= 1'b0;
            r_faults    <= '0;
            r_accesses  <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_use       <= n_use;
            r_dirty     <= n_dirty;
            r_hand      <= n_hand;
            r_steps     <= n_steps;
            r_hit       <= n_hit;
            r_faults    <= n_faults;
            r_accesses  <= n_accesses;
            r_res_valid <= n_res_valid;
        end
    end

    // Hold the current request, the slot and the result payload
    always_ff @(posedge i_clk) begin
        if (o_item_pop) begin
            r_cur_page <= i_item_page;
            r_cur_wr   <= i_item_wr;
        end
        if ((r_state == S_SWEEP) && replace) begin
            r_page[r_hand] <= r_cur_page;
        end
        r_slot <= n_slot;
        r_res  <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// File: hw/rtl/enhanced_clock_page_replacement.sv
// A request passes the request queue, the lookup and, on a miss, the sweep that
// checks one frame per cycle, before the result register takes its result.
// The back end takes a new request only after it has written the last result to the result register.
// A two-entry request queue and a result register let each side stall on its own.
// Synchronous active-low reset empties all frames, parks the hand at frame 0
// and clears both counters; no clearing pass is needed.
module enhanced_clock_page_replacement #(
    parameter int unsigned FRAMES    = 3,
    parameter int unsigned PAGE_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  ecpr_pkg::t_req i_req,
    output logic           o_req_stall,
    output logic           o_res_valid,
    output ecpr_pkg::t_res o_res,
    input  logic           i_res_stall
);

    logic                 item_valid;
    logic [PAGE_BITS-1:0] item_page;
    logic                 item_wr;
    logic                 item_pop;

    // Queue incoming requests
    ecpr_front #(
        .PAGE_BITS (PAGE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .i_req        (i_req),
        .o_req_stall  (o_req_stall),
        .o_item_valid (item_valid),
        .o_item_page  (item_page),
        .o_item_wr    (item_wr),
        .i_item_pop   (item_pop)
    );

    // Look up, sweep and replace
    ecpr_back #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item_page  (item_page),
        .i_item_wr    (item_wr),
        .o_item_pop   (item_pop),
        .o_res_valid  (o_res_valid),
        .o_res        (o_res),
        .i_res_stall  (i_res_stall)
    );

    // Every result counts at least its own access
    a_access_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.access_total != '0))
        else $error("result with zero access count");

    // Faults never outrun accesses
    a_fault_le_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.fault_total <= o_res.access_total))
        else $error("fault count above access count");

    // A miss has counted at least one fault
    a_miss_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.hit) |-> (o_res.fault_total != '0))
        else $error("miss reported with zero fault count");

endmodule
